### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros for the dns a record extractor checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication, also checked across reset
`define ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/dnsa_pkg.sv
// ----------------------------------------------------------------------------
// dnsa_pkg
// shared types and constants of the dns a record extractor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dnsa_pkg;

    localparam int MAX_PACKET_DEF = 512;

    localparam int          HDR_LEN   = 12;
    localparam logic [15:0] FIXED_LEN = 16'd10;
    localparam logic [15:0] QFIX_LEN  = 16'd4;
    localparam logic [15:0] ADDR_LEN  = 16'd4;
    localparam logic [7:0]  PTR_MARK  = 8'hC0;
    localparam logic [15:0] TYPE_A    = 16'd1;
    localparam logic [15:0] CLASS_IN  = 16'd1;

    typedef enum logic [11:0] {
        PH_HEADER = 12'b0000_0000_0001,
        PH_QNAME  = 12'b0000_0000_0010,
        PH_QLABEL = 12'b0000_0000_0100,
        PH_QPTR   = 12'b0000_0000_1000,
        PH_QFIXED = 12'b0000_0001_0000,
        PH_ANAME  = 12'b0000_0010_0000,
        PH_ALABEL = 12'b0000_0100_0000,
        PH_APTR   = 12'b0000_1000_0000,
        PH_AFIXED = 12'b0001_0000_0000,
        PH_RDSKIP = 12'b0010_0000_0000,
        PH_ADDR   = 12'b0100_0000_0000,
        PH_IDLE   = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        logic        found;
        logic [31:0] ipv4_address;
    } result_t;

endpackage

### rtl/dnsa_parser.sv
// ----------------------------------------------------------------------------
// dnsa_parser
// per-byte message parser state, emits at most one result per transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dnsa_parser
    import dnsa_pkg::*;
#(
    parameter int MAX_PACKET = MAX_PACKET_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  packet_byte,
    input  logic        last_byte,
    output logic        res_valid,
    output result_t     res
);

    localparam int POS_W = $clog2(MAX_PACKET + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET);

    logic [POS_W-1:0] pos_reg, pos_next;
    phase_t           phase_reg, phase_next;
    logic [15:0]      skip_reg, skip_next;
    logic [15:0]      ans_reg, ans_next;
    logic [47:0]      fixed_reg, fixed_next;
    logic [31:0]      addr_reg, addr_next;
    logic             seen_reg, seen_next;

    logic        parse_en;
    logic        match;
    logic [15:0] skip_dec;
    logic [15:0] ans_dec;
    logic [15:0] byte_ext;

    always_comb begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        skip_next  = skip_reg;
        ans_next   = ans_reg;
        fixed_next = fixed_reg;
        addr_next  = addr_reg;
        seen_next  = seen_reg;
        match      = 1'b0;
        skip_dec   = skip_reg - 16'd1;
        ans_dec    = ans_reg - 16'd1;
        byte_ext   = {8'd0, packet_byte};
        parse_en   = !seen_reg && (pos_reg < POS_MAX);

        if (parse_en) begin
            case (phase_reg)
                PH_HEADER: begin
                    if (pos_reg == POS_W'(6) || pos_reg == POS_W'(7)) begin
                        ans_next = {ans_reg[7:0], packet_byte};
                    end
                    if (pos_reg == POS_W'(HDR_LEN - 1)) begin
                        phase_next = PH_QNAME;
                    end
                end
                PH_QNAME: begin
                    if (packet_byte == 8'd0) begin
                        phase_next = PH_QFIXED;
                        skip_next  = QFIX_LEN;
                    end else if ((packet_byte & PTR_MARK) == PTR_MARK) begin
                        phase_next = PH_QPTR;
                    end else begin
                        phase_next = PH_QLABEL;
                        skip_next  = byte_ext;
                    end
                end
                PH_QLABEL: begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0) begin
                        phase_next = PH_QNAME;
                    end
                end
                PH_QPTR: begin
                    phase_next = PH_QFIXED;
                    skip_next  = QFIX_LEN;
                end
                PH_QFIXED: begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0) begin
                        phase_next = (ans_reg == 16'd0) ? PH_IDLE : PH_ANAME;
                    end
                end
                PH_ANAME: begin
                    if (packet_byte == 8'd0) begin
                        phase_next = PH_AFIXED;
                        skip_next  = FIXED_LEN;
                        fixed_next = '0;
                    end else if ((packet_byte & PTR_MARK) == PTR_MARK) begin
                        phase_next = PH_APTR;
                    end else begin
                        phase_next = PH_ALABEL;
                        skip_next  = byte_ext;
                    end
                end
                PH_ALABEL: begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0) begin
                        phase_next = PH_ANAME;
                    end
                end
                PH_APTR: begin
                    phase_next = PH_AFIXED;
                    skip_next  = FIXED_LEN;
                    fixed_next = '0;
                end
                PH_AFIXED: begin
                    // type and class bytes, then rdata length; ttl is dropped
                    if (skip_reg > 16'd6 || skip_reg <= 16'd2) begin
                        fixed_next = {fixed_reg[39:0], packet_byte};
                    end
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0) begin
                        if (fixed_next[47:32] == TYPE_A && fixed_next[31:16] == CLASS_IN
                                && fixed_next[15:0] == ADDR_LEN) begin
                            phase_next = PH_ADDR;
                            skip_next  = ADDR_LEN;
                            addr_next  = '0;
                        end else begin
                            ans_next = ans_dec;
                            if (fixed_next[15:0] == 16'd0) begin
                                phase_next = (ans_dec == 16'd0) ? PH_IDLE : PH_ANAME;
                            end else begin
                                phase_next = PH_RDSKIP;
                                skip_next  = fixed_next[15:0];
                            end
                        end
                    end
                end
                PH_RDSKIP: begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0) begin
                        phase_next = (ans_reg == 16'd0) ? PH_IDLE : PH_ANAME;
                    end
                end
                PH_ADDR: begin
                    addr_next = {addr_reg[23:0], packet_byte};
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0) begin
                        phase_next = PH_IDLE;
                        match      = 1'b1;
                    end
                end
                PH_IDLE: begin
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        if (pos_reg != POS_MAX) begin
            pos_next = pos_reg + POS_W'(1);
        end
        seen_next = seen_reg | match;

        res_valid        = match || (last_byte && !seen_reg);
        res.found        = match;
        res.ipv4_address = match ? addr_next : 32'd0;

        // end of message returns everything to the start state
        if (last_byte) begin
            pos_next   = '0;
            phase_next = PH_HEADER;
            skip_next  = '0;
            ans_next   = '0;
            fixed_next = '0;
            addr_next  = '0;
            seen_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            phase_reg <= PH_HEADER;
            skip_reg  <= '0;
            ans_reg   <= '0;
            fixed_reg <= '0;
            addr_reg  <= '0;
            seen_reg  <= 1'b0;
        end else if (step) begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            ans_reg   <= ans_next;
            fixed_reg <= fixed_next;
            addr_reg  <= addr_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

### rtl/dnsa_out_buf.sv
// ----------------------------------------------------------------------------
// dnsa_out_buf
// two-entry result buffer between the parser and the result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dnsa_out_buf
    import dnsa_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    can_push,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    localparam logic [1:0] DEPTH = 2'd2;

    result_t    slot_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    always_comb begin
        out_valid   = (count_reg != 2'd0);
        can_push    = (count_reg != DEPTH);
        out_data    = slot_mem[rd_ptr_reg];
        pop         = out_valid && out_ready;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/dns_a_record_extractor.sv
// Takes a DNS response one byte per transaction on the s_ side (s_tlast on the final byte)
// and gives exactly one result per message on the m_ side: m_tuser high with the IPv4
// address of the first A record (type 1, class 1, rdata length 4), or m_tuser low with a
// zero address when the message ends without one. A byte is parsed in the cycle it is
// accepted, one byte every cycle while s_tready is high; the result is written to the
// buffer with the byte that completes the address or with the last byte. Results wait in
// a two-entry buffer, so s_tready drops only while both entries hold results that
// m_tready has not taken. Bytes at position MAX_PACKET or later are not parsed.
// ----------------------------------------------------------------------------
// dns_a_record_extractor
// streaming dns response parser that reports the first a record address
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dns_a_record_extractor
    import dnsa_pkg::*;
#(
    parameter int MAX_PACKET = MAX_PACKET_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] packet_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] ipv4_address
    output logic        m_tuser    // [0] found
);

    logic    step;
    logic    res_valid;
    result_t res;
    result_t head;
    logic    can_push;

    assign s_tready = can_push;
    assign step     = s_tvalid && can_push;

    dnsa_parser #(
        .MAX_PACKET (MAX_PACKET)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .packet_byte (s_tdata),
        .last_byte   (s_tlast),
        .res_valid   (res_valid),
        .res         (res)
    );

    dnsa_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step && res_valid),
        .push_data (res),
        .can_push  (can_push),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    assign m_tdata = head.ipv4_address;
    assign m_tuser = head.found;

endmodule

### rtl/dnsa_checker.sv
// ----------------------------------------------------------------------------
// dnsa_checker
// port-level checks of the dns a record extractor, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dnsa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    `ASSERT_NXT(a_valid_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NXT(a_data_holds, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    `ASSERT_IMP(a_miss_zero_addr, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == 32'd0)
    `ASSERT_NXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid && s_tready)

endmodule

bind dns_a_record_extractor dnsa_checker u_dnsa_checker (.*);

### test/dns_a_record_extractor_tb.sv
// ----------------------------------------------------------------------------
// dns_a_record_extractor_tb
// Self-checking testbench for the dns a record extractor. Whole DNS response
// messages are streamed into the parser one byte per transaction. A cycle
// model of the parser runs alongside and queues the report that each message
// should give. Every report on the m_ side is checked against it in order.
// Directed messages cover short and truncated messages, the name forms,
// skipped records, the answer count extremes and the packet size limit.
// Random well-formed responses and noise follow. Both sides idle and stall
// at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dns_a_record_extractor_tb;
    import dnsa_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_BYTES  = 150;
    localparam int RANDOM_MSGS   = 8;
    localparam int DRAIN_CYCLES  = 10;

    typedef enum int {
        NAME_ROOT,
        NAME_PTR,
        NAME_LABELS,
        NAME_ODD_LABELS
    } name_style_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    // parser model state
    logic [15:0] p_pos;
    phase_t      p_phase;
    logic [15:0] p_remain;
    logic [15:0] p_answers;
    logic [63:0] p_fixed;
    logic [31:0] p_addr;
    bit          p_matched;

    result_t     dns_reports_due[$];
    result_t     oldest_report;
    logic [7:0]  msg_bytes[$];

    bit idle_on = 1'b1;
    int m_stall_left = 0;
    int mismatches = 0;
    int cycles = 0;
    int bytes_sent = 0;
    int msgs_sent = 0;
    int hits_predicted = 0;
    int misses_predicted = 0;

    dns_a_record_extractor uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL dns_a_record_extractor");
            $finish;
        end
    end

    function int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------
    function void clear_parser();
        p_pos     = '0;
        p_phase   = PH_HEADER;
        p_remain  = '0;
        p_answers = '0;
        p_fixed   = '0;
        p_addr    = '0;
        p_matched = 1'b0;
    endfunction

    function void next_record();
        p_phase = (p_answers == 16'd0) ? PH_IDLE : PH_ANAME;
    endfunction

    function void walk_name(input logic [7:0] b, input phase_t label_ph, input phase_t ptr_ph,
                            input phase_t after_ph, input logic [15:0] after_len);
        if (b == 8'd0) begin
            p_phase  = after_ph;
            p_remain = after_len;
        end else if ((b & PTR_MARK) == PTR_MARK) begin
            p_phase = ptr_ph;
        end else begin
            p_phase  = label_ph;
            p_remain = {8'd0, b};
        end
    endfunction

    function void parse_dns_byte(input logic [7:0] b, input bit last);
        bit          hit;
        logic [15:0] idx;
        logic [15:0] rdlen;
        hit = 1'b0;
        if (!p_matched && p_pos < MAX_PACKET_DEF) begin
            case (p_phase)
                PH_HEADER: begin
                    if (p_pos == 16'd6 || p_pos == 16'd7)
                        p_answers = {p_answers[7:0], b};
                    if (p_pos == HDR_LEN - 1)
                        p_phase = PH_QNAME;
                end
                PH_QNAME: walk_name(b, PH_QLABEL, PH_QPTR, PH_QFIXED, QFIX_LEN);
                PH_QLABEL: begin
                    p_remain--;
                    if (p_remain == 16'd0)
                        p_phase = PH_QNAME;
                end
                PH_QPTR: begin
                    p_phase  = PH_QFIXED;
                    p_remain = QFIX_LEN;
                end
                PH_QFIXED: begin
                    p_remain--;
                    if (p_remain == 16'd0)
                        next_record();
                end
                PH_ANAME: begin
                    walk_name(b, PH_ALABEL, PH_APTR, PH_AFIXED, FIXED_LEN);
                    if (p_phase == PH_AFIXED)
                        p_fixed = '0;
                end
                PH_ALABEL: begin
                    p_remain--;
                    if (p_remain == 16'd0)
                        p_phase = PH_ANAME;
                end
                PH_APTR: begin
                    p_phase  = PH_AFIXED;
                    p_remain = FIXED_LEN;
                    p_fixed  = '0;
                end
                PH_AFIXED: begin
                    // ttl bytes are not kept
                    idx = FIXED_LEN - p_remain;
                    if (idx < 16'd4 || idx >= 16'd8)
                        p_fixed = {p_fixed[55:0], b};
                    p_remain--;
                    if (p_remain == 16'd0) begin
                        rdlen = p_fixed[15:0];
                        if (p_fixed[47:32] == TYPE_A && p_fixed[31:16] == CLASS_IN &&
                            rdlen == ADDR_LEN) begin
                            p_phase  = PH_ADDR;
                            p_remain = ADDR_LEN;
                            p_addr   = '0;
                        end else begin
                            p_answers--;
                            if (rdlen == 16'd0) begin
                                next_record();
                            end else begin
                                p_phase  = PH_RDSKIP;
                                p_remain = rdlen;
                            end
                        end
                    end
                end
                PH_RDSKIP: begin
                    p_remain--;
                    if (p_remain == 16'd0)
                        next_record();
                end
                PH_ADDR: begin
                    p_addr = {p_addr[23:0], b};
                    p_remain--;
                    if (p_remain == 16'd0) begin
                        p_phase = PH_IDLE;
                        hit     = 1'b1;
                    end
                end
                default: ;
            endcase
            if (hit) begin
                p_matched = 1'b1;
                dns_reports_due.push_back('{1'b1, p_addr});
                hits_predicted++;
            end
        end
        if (p_pos != 16'hFFFF)
            p_pos++;
        if (last) begin
            if (!p_matched) begin
                dns_reports_due.push_back('{1'b0, 32'd0});
                misses_predicted++;
            end
            clear_parser();
        end
    endfunction

    // ------------------------------------------------------------------
    // result checking and m_ side stalls
    // ------------------------------------------------------------------
    task report_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
        $display("mismatch in %s: expected %h, got %h", what, want, got);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (dns_reports_due.size() == 0) begin
                report_mismatch("unexpected report, address", 32'd0, m_tdata);
            end else begin
                oldest_report = dns_reports_due.pop_front();
                if (m_tuser !== oldest_report.found)
                    report_mismatch("found flag", {31'd0, oldest_report.found}, {31'd0, m_tuser});
                if (m_tdata !== oldest_report.ipv4_address)
                    report_mismatch("ipv4 address", oldest_report.ipv4_address, m_tdata);
            end
        end
        if (m_stall_left > 0)
            m_stall_left--;
        else if ($urandom_range(0, 7) == 0)
            m_stall_left = rand_gap();
        m_tready <= (m_stall_left == 0);
    end

    // ------------------------------------------------------------------
    // byte transactions and message building
    // ------------------------------------------------------------------
    task send_byte(input logic [7:0] b, input bit last);
        int gap;
        gap = rand_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        parse_dns_byte(b, last);
        bytes_sent++;
    endtask

    task send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        if (msg_bytes.size() > 0)
            msgs_sent++;
    endtask

    function void add_noise(input int n);
        for (int i = 0; i < n; i++)
            msg_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function void start_message(input logic [15:0] ancount);
        msg_bytes.delete();
        add_noise(HDR_LEN);
        msg_bytes[6] = ancount[15:8];
        msg_bytes[7] = ancount[7:0];
    endfunction

    function void truncate_message(input int n);
        while (msg_bytes.size() > n)
            void'(msg_bytes.pop_back());
    endfunction

    function void add_label(input int len);
        msg_bytes.push_back(8'(len));
        add_noise(len);
    endfunction

    function void add_pointer();
        msg_bytes.push_back(PTR_MARK | 8'($urandom_range(0, 63)));
        msg_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function void add_name(input name_style_t style);
        int n;
        case (style)
            NAME_ROOT: msg_bytes.push_back(8'd0);
            NAME_PTR:  add_pointer();
            default: begin
                n = (style == NAME_ODD_LABELS) ? 1 : $urandom_range(1, 3);
                for (int i = 0; i < n; i++) begin
                    if (style == NAME_ODD_LABELS)
                        add_label($urandom_range(64, 191));
                    else if ($urandom_range(0, 9) == 0)
                        add_label($urandom_range(13, 63));
                    else
                        add_label($urandom_range(1, 12));
                end
                if ($urandom_range(0, 1) == 0)
                    msg_bytes.push_back(8'd0);
                else
                    add_pointer();
            end
        endcase
    endfunction

    function void add_question(input name_style_t style);
        add_name(style);
        add_noise(4);
    endfunction

    function void add_record(input name_style_t style, input logic [15:0] rtype,
                             input logic [15:0] rclass, input logic [15:0] rdlen,
                             input logic [31:0] addr);
        add_name(style);
        msg_bytes.push_back(rtype[15:8]);
        msg_bytes.push_back(rtype[7:0]);
        msg_bytes.push_back(rclass[15:8]);
        msg_bytes.push_back(rclass[7:0]);
        add_noise(4);
        msg_bytes.push_back(rdlen[15:8]);
        msg_bytes.push_back(rdlen[7:0]);
        for (int i = 0; i < rdlen; i++) begin
            if (rdlen == ADDR_LEN)
                msg_bytes.push_back(addr[31 - 8 * i -: 8]);
            else
                msg_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function void add_a_record(input name_style_t style, input logic [31:0] addr);
        add_record(style, TYPE_A, CLASS_IN, ADDR_LEN, addr);
    endfunction

    function name_style_t any_style();
        return name_style_t'($urandom_range(0, 3));
    endfunction

    function logic [15:0] rand16(input int hi);
        return 16'($urandom_range(0, hi));
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task test_short_messages();
        msg_bytes.delete();
        add_noise(1);
        send_message();
        start_message(16'd1);
        truncate_message(HDR_LEN - 1);
        send_message();
        start_message(16'd1);
        send_message();
        // no answers: rest of the message is ignored
        start_message(16'd0);
        add_question(NAME_PTR);
        add_a_record(NAME_PTR, $urandom);
        send_message();
    endtask

    task test_a_record();
        start_message(16'd1);
        add_question(NAME_PTR);
        add_a_record(NAME_PTR, 32'hFFFF_FFFF);
        send_message();
        start_message(16'd1);
        add_question(NAME_ROOT);
        add_a_record(NAME_ROOT, 32'h0000_0000);
        add_noise(6);
        send_message();
        start_message(16'd2);
        add_question(NAME_LABELS);
        add_a_record(NAME_LABELS, $urandom);
        add_a_record(NAME_PTR, $urandom);
        send_message();
        start_message(16'd1);
        msg_bytes.push_back(8'hFF);
        msg_bytes.push_back(8'hFF);
        add_noise(4);
        msg_bytes.push_back(PTR_MARK);
        msg_bytes.push_back(8'h00);
        truncate_message(msg_bytes.size() - 2);
        add_record(NAME_ROOT, TYPE_A, CLASS_IN, ADDR_LEN, $urandom);
        send_message();
    endtask

    task test_name_forms();
        start_message(16'd1);
        add_label(63);
        add_label(64);
        msg_bytes.push_back(8'd0);
        add_noise(4);
        add_label(191);
        add_label(127);
        add_pointer();
        truncate_message(msg_bytes.size() - 2);
        msg_bytes.push_back(8'd0);
        add_record(NAME_PTR, TYPE_A, CLASS_IN, ADDR_LEN, $urandom);
        send_message();
        start_message(16'd1);
        add_label(128);
        add_pointer();
        add_noise(4);
        add_label(65);
        msg_bytes.push_back(8'd0);
        add_record(NAME_PTR, TYPE_A, CLASS_IN, ADDR_LEN, $urandom);
        send_message();
    endtask

    task test_skipped_records();
        start_message(16'd6);
        add_question(NAME_PTR);
        add_record(NAME_PTR, 16'd28, CLASS_IN, 16'd16, 32'd0);
        add_record(NAME_PTR, TYPE_A, 16'd3, ADDR_LEN, $urandom);
        add_record(NAME_ROOT, TYPE_A, CLASS_IN, 16'd0, 32'd0);
        add_record(NAME_LABELS, TYPE_A, CLASS_IN, 16'd5, 32'd0);
        add_record(NAME_PTR, 16'd5, CLASS_IN, 16'd0, 32'd0);
        add_a_record(NAME_PTR, $urandom);
        send_message();
        start_message(16'd2);
        add_question(NAME_LABELS);
        add_record(NAME_PTR, 16'd15, CLASS_IN, 16'd3, 32'd0);
        add_record(NAME_PTR, TYPE_A, CLASS_IN, 16'd8, 32'd0);
        add_noise(5);
        send_message();
        // answers used up before the a record
        start_message(16'd1);
        add_question(NAME_PTR);
        add_record(NAME_PTR, 16'hFFFF, 16'hFFFF, 16'd2, 32'd0);
        add_a_record(NAME_PTR, $urandom);
        send_message();
        start_message(16'hFFFF);
        add_question(NAME_PTR);
        add_record(NAME_ROOT, 16'd2, CLASS_IN, 16'd1, 32'd0);
        add_a_record(NAME_PTR, $urandom);
        send_message();
        start_message(16'h0100);
        add_question(NAME_ROOT);
        add_record(NAME_PTR, TYPE_A, 16'h0100, ADDR_LEN, $urandom);
        add_a_record(NAME_LABELS, $urandom);
        send_message();
    endtask

    task test_truncated();
        int full;
        start_message(16'd1);
        add_question(NAME_LABELS);
        add_a_record(NAME_PTR, $urandom);
        full = msg_bytes.size();
        truncate_message(full - 6);
        send_message();
        start_message(16'd1);
        add_question(NAME_PTR);
        add_a_record(NAME_PTR, $urandom);
        truncate_message(msg_bytes.size() - 1);
        send_message();
        start_message(16'd1);
        add_label(20);
        truncate_message(HDR_LEN + 8);
        send_message();
    endtask

    // address ends at position MAX_PACKET_DEF - 2 + tail_len - 29
    task long_qname_message(input int tail_len);
        start_message(16'd1);
        for (int i = 0; i < 7; i++)
            add_label(63);
        add_label(tail_len);
        msg_bytes.push_back(8'd0);
        add_noise(4);
        add_a_record(NAME_PTR, $urandom);
        add_noise(3);
        send_message();
    endtask

    task test_oversize();
        long_qname_message(30);
        long_qname_message(31);
    endtask

    task random_message();
        int n_ans;
        int n_rec;
        int pick;
        if ($urandom_range(0, 99) < 80) begin
            n_ans = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4);
            start_message(16'(n_ans));
            add_question(any_style());
            n_rec = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : ((n_ans > 5) ? 5 : n_ans);
            for (int i = 0; i < n_rec; i++) begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    add_a_record(any_style(), $urandom);
                else if (pick == 4)
                    add_record(any_style(), TYPE_A, CLASS_IN, rand16(8), $urandom);
                else if (pick == 5)
                    add_record(any_style(), rand16(65535), CLASS_IN, ADDR_LEN, $urandom);
                else if (pick == 6)
                    add_record(any_style(), TYPE_A, rand16(65535), ADDR_LEN, $urandom);
                else if (pick == 7)
                    add_record(any_style(), rand16(3), rand16(3), 16'd0, 32'd0);
                else
                    add_record(any_style(), rand16(65535), rand16(65535), rand16(20), $urandom);
            end
            if ($urandom_range(0, 3) == 0)
                add_noise($urandom_range(1, 8));
            if ($urandom_range(0, 9) == 0)
                truncate_message($urandom_range(1, msg_bytes.size()));
        end else begin
            msg_bytes.delete();
            add_noise(($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 40));
        end
        send_message();
    endtask

    task test_random();
        int first_byte;
        int msgs;
        first_byte = bytes_sent;
        msgs = 0;
        while (bytes_sent - first_byte < RANDOM_BYTES || msgs < RANDOM_MSGS) begin
            if (msgs % 6 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            random_message();
            msgs++;
        end
        idle_on = 1'b1;
    endtask

    initial begin
        clear_parser();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_short_messages();
        test_a_record();
        test_name_forms();
        test_skipped_records();
        test_truncated();
        test_oversize();
        test_random();
        s_tvalid <= 1'b0;
        while (dns_reports_due.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("sent %0d messages, %0d bytes, in %0d cycles", msgs_sent, bytes_sent, cycles);
        $display("%0d reports with an address, %0d without", hits_predicted, misses_predicted);
        if (mismatches == 0) begin
            $display("PASS dns_a_record_extractor");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL dns_a_record_extractor");
        end
        $finish;
    end

endmodule
